/* hdl/amp_rpp_pkg.sv */
// Package for the amplifier reply poll parser: operation and result codes,
// parser state encodings, character constants and the result beat struct.
// No dependencies.
package amp_rpp_pkg;

   localparam logic OP_START = 1'b0;
   localparam logic OP_BYTE  = 1'b1;

   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_V     = 8'h76;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_VT    = 8'h0B;
   localparam logic [7:0] CHAR_FF    = 8'h0C;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   localparam logic [34:0] MAG_LIMIT = 35'h0_8000_0000;
   localparam logic [31:0] VALUE_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] VALUE_MIN = 32'h8000_0000;

   typedef enum logic [1:0] {
      PHASE_IDLE = 2'd0,
      PHASE_POS  = 2'd1,
      PHASE_CUR  = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      PREFIX_START = 2'd0,
      PREFIX_V     = 2'd1,
      PREFIX_OK    = 2'd2,
      PREFIX_BAD   = 2'd3
   } prefix_type;

   typedef enum logic [1:0] {
      NUM_SKIP   = 2'd0,
      NUM_SIGN   = 2'd1,
      NUM_DIGITS = 2'd2,
      NUM_STOP   = 2'd3
   } number_type;

   typedef enum logic [1:0] {
      KIND_POS_QUERY = 2'd0,
      KIND_POS_DONE  = 2'd1,
      KIND_CUR_DONE  = 2'd2
   } kind_type;

   typedef struct packed {
      logic        valid;
      kind_type    kind;
      logic [31:0] value;
      logic        reply_ok;
   } result_type;

endpackage

/* hdl/amp_rpp_line.sv */
// Line parser of the amplifier reply poll parser: holds the poll phase and the
// running parse of the current reply line, and forms the result of each beat.
// Depends on amp_rpp_pkg.
module amp_rpp_line #(
   parameter int BUFFER_DEPTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic                   op,
   input  logic [7:0]             rx_byte,
   output amp_rpp_pkg::result_type result
);

   localparam int CW = $clog2(BUFFER_DEPTH);
   localparam logic [CW-1:0] CountLimit = CW'(BUFFER_DEPTH - 1);

   amp_rpp_pkg::phase_type  phase_ff, phase_in;
   amp_rpp_pkg::prefix_type prefix_ff, prefix_in;
   amp_rpp_pkg::number_type stage_ff, stage_in;
   logic [CW-1:0]           count_ff, count_in;
   logic                    negative_ff, negative_in;
   logic [31:0]             magnitude_ff, magnitude_in;
   logic                    overflowed_ff, overflowed_in;

   logic        is_digit;
   logic        is_space;
   logic        add_digit;
   logic [34:0] mag_wide;
   logic [34:0] mag_next;
   logic [31:0] parsed;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= amp_rpp_pkg::PHASE_IDLE;
         prefix_ff     <= amp_rpp_pkg::PREFIX_START;
         stage_ff      <= amp_rpp_pkg::NUM_SKIP;
         count_ff      <= '0;
         negative_ff   <= 1'b0;
         magnitude_ff  <= '0;
         overflowed_ff <= 1'b0;
      end else if (accept) begin
         phase_ff      <= phase_in;
         prefix_ff     <= prefix_in;
         stage_ff      <= stage_in;
         count_ff      <= count_in;
         negative_ff   <= negative_in;
         magnitude_ff  <= magnitude_in;
         overflowed_ff <= overflowed_in;
      end
   end

   assign is_digit = rx_byte inside {[amp_rpp_pkg::CHAR_ZERO : amp_rpp_pkg::CHAR_NINE]};
   assign is_space = rx_byte inside {amp_rpp_pkg::CHAR_SPACE, amp_rpp_pkg::CHAR_TAB,
                                     amp_rpp_pkg::CHAR_LF, amp_rpp_pkg::CHAR_VT,
                                     amp_rpp_pkg::CHAR_FF, amp_rpp_pkg::CHAR_CR};

   assign mag_wide = {3'b000, magnitude_ff};
   assign mag_next = (mag_wide << 3) + (mag_wide << 1) + {31'd0, rx_byte[3:0]};

   always_comb begin
      if (prefix_ff != amp_rpp_pkg::PREFIX_OK) begin
         parsed = '0;
      end else if (overflowed_ff) begin
         parsed = negative_ff ? amp_rpp_pkg::VALUE_MIN : amp_rpp_pkg::VALUE_MAX;
      end else if (negative_ff) begin
         parsed = 32'd0 - magnitude_ff;
      end else if (magnitude_ff > amp_rpp_pkg::VALUE_MAX) begin
         parsed = amp_rpp_pkg::VALUE_MAX;
      end else begin
         parsed = magnitude_ff;
      end
   end

   always_comb begin
      phase_in      = phase_ff;
      prefix_in     = prefix_ff;
      stage_in      = stage_ff;
      count_in      = count_ff;
      negative_in   = negative_ff;
      magnitude_in  = magnitude_ff;
      overflowed_in = overflowed_ff;
      add_digit     = 1'b0;
      result        = '0;

      if (op == amp_rpp_pkg::OP_START) begin
         phase_in      = amp_rpp_pkg::PHASE_POS;
         prefix_in     = amp_rpp_pkg::PREFIX_START;
         stage_in      = amp_rpp_pkg::NUM_SKIP;
         count_in      = '0;
         negative_in   = 1'b0;
         magnitude_in  = '0;
         overflowed_in = 1'b0;
         result.valid  = 1'b1;
         result.kind   = amp_rpp_pkg::KIND_POS_QUERY;
      end else if (rx_byte == amp_rpp_pkg::CHAR_CR) begin
         result.reply_ok = (prefix_ff == amp_rpp_pkg::PREFIX_OK);
         case (phase_ff)
            amp_rpp_pkg::PHASE_POS: begin
               result.valid = 1'b1;
               result.kind  = amp_rpp_pkg::KIND_POS_DONE;
               result.value = parsed;
               phase_in     = amp_rpp_pkg::PHASE_CUR;
            end
            amp_rpp_pkg::PHASE_CUR: begin
               result.valid = 1'b1;
               result.kind  = amp_rpp_pkg::KIND_CUR_DONE;
               result.value = {{16{parsed[15]}}, parsed[15:0]};
               phase_in     = amp_rpp_pkg::PHASE_IDLE;
            end
            default: begin
               result.valid = 1'b0;
            end
         endcase
         prefix_in     = amp_rpp_pkg::PREFIX_START;
         stage_in      = amp_rpp_pkg::NUM_SKIP;
         count_in      = '0;
         negative_in   = 1'b0;
         magnitude_in  = '0;
         overflowed_in = 1'b0;
      end else if (count_ff < CountLimit) begin
         count_in = count_ff + 1'b1;
         case (prefix_ff)
            amp_rpp_pkg::PREFIX_START: begin
               prefix_in = (rx_byte == amp_rpp_pkg::CHAR_V) ?
                           amp_rpp_pkg::PREFIX_V : amp_rpp_pkg::PREFIX_BAD;
            end
            amp_rpp_pkg::PREFIX_V: begin
               prefix_in = (rx_byte == amp_rpp_pkg::CHAR_SPACE) ?
                           amp_rpp_pkg::PREFIX_OK : amp_rpp_pkg::PREFIX_BAD;
            end
            amp_rpp_pkg::PREFIX_OK: begin
               case (stage_ff)
                  amp_rpp_pkg::NUM_SKIP: begin
                     if (is_space) begin
                        stage_in = amp_rpp_pkg::NUM_SKIP;
                     end else if (rx_byte == amp_rpp_pkg::CHAR_PLUS) begin
                        stage_in = amp_rpp_pkg::NUM_SIGN;
                     end else if (rx_byte == amp_rpp_pkg::CHAR_MINUS) begin
                        negative_in = 1'b1;
                        stage_in    = amp_rpp_pkg::NUM_SIGN;
                     end else if (is_digit) begin
                        add_digit = 1'b1;
                        stage_in  = amp_rpp_pkg::NUM_DIGITS;
                     end else begin
                        stage_in = amp_rpp_pkg::NUM_STOP;
                     end
                  end
                  amp_rpp_pkg::NUM_SIGN, amp_rpp_pkg::NUM_DIGITS: begin
                     if (is_digit) begin
                        add_digit = 1'b1;
                        stage_in  = amp_rpp_pkg::NUM_DIGITS;
                     end else begin
                        stage_in = amp_rpp_pkg::NUM_STOP;
                     end
                  end
                  default: begin
                     stage_in = stage_ff;
                  end
               endcase
            end
            default: begin
               prefix_in = prefix_ff;
            end
         endcase
      end

      if (add_digit && !overflowed_ff) begin
         if (mag_next > amp_rpp_pkg::MAG_LIMIT) begin
            overflowed_in = 1'b1;
         end else begin
            magnitude_in = mag_next[31:0];
         end
      end
   end

endmodule

/* hdl/amp_reply_poll_parser.sv */
// Top level of the amplifier reply poll parser: request handshake, line parser
// instance and the result register.
// Depends on amp_rpp_pkg and amp_rpp_line.
//
// One request beat carries an operation: start a poll cycle, or one received
// byte of the amplifier's reply. A start beat always gives a position-query
// result. A carriage return ends a reply line and gives a position or current
// result when a query is outstanding; every other byte gives no result.
// Bytes beyond the line capacity of BUFFER_DEPTH-1 are dropped.
// A request beat is taken in every cycle in which the result register is
// empty, is being emptied, or holds a result that is not stalled, so the
// block sustains one beat per cycle. A result appears on the rsp_ channel in the
// cycle after the request beat that caused it and is held unchanged while
// rsp_stall is high; req_stall follows rsp_stall whenever the result register
// holds a result, whatever the next request beat is. The synchronous reset
// returns the poll phase to idle, clears the line and empties the result
// register.
module amp_reply_poll_parser #(
   parameter int BUFFER_DEPTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_op,
   input  logic [7:0]         req_rx_byte,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_kind,
   output logic signed [31:0] rsp_value,
   output logic               rsp_reply_ok
);

   amp_rpp_pkg::result_type result;
   amp_rpp_pkg::result_type out_ff, out_in;
   logic                    req_beat;

   assign req_stall = out_ff.valid & rsp_stall;
   assign req_beat  = req_valid & ~req_stall;

   amp_rpp_line #(
      .BUFFER_DEPTH(BUFFER_DEPTH)
   ) u_line (
      .clock   (clock),
      .reset   (reset),
      .accept  (req_beat),
      .op      (req_op),
      .rx_byte (req_rx_byte),
      .result  (result)
   );

   always_comb begin
      out_in = out_ff;
      if (out_ff.valid && !rsp_stall) begin
         out_in.valid = 1'b0;
      end
      if (req_beat && result.valid) begin
         out_in = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff <= '0;
      end else begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid    = out_ff.valid;
   assign rsp_kind     = out_ff.kind;
   assign rsp_value    = $signed(out_ff.value);
   assign rsp_reply_ok = out_ff.reply_ok;

endmodule

/* tb/testbench.sv */
// Self-checking testbench for amp_reply_poll_parser: directed reply lines, then random poll
// traffic, with random gaps on both channels, checked against an in-line model of the parser.
// Depends on amp_rpp_pkg and the RTL of amp_reply_poll_parser.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LINE_DEPTH     = 32;
   localparam int RANDOM_BEATS   = 1200;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 8;
   localparam int MAX_PRINTED    = 30;

   typedef struct {
      amp_rpp_pkg::kind_type kind;
      logic [31:0]           value;
      logic                  reply_ok;
   } poll_result_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic               req_op = amp_rpp_pkg::OP_START;
   logic [7:0]         req_rx_byte = 8'h00;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [1:0]         rsp_kind;
   logic signed [31:0] rsp_value;
   logic               rsp_reply_ok;

   poll_result_type pending_results[$];
   int              mismatch_count = 0;
   int              beats_sent = 0;
   int              quiet_cycles = 0;
   int              stall_hold = 0;
   bit              gaps_on = 1'b0;

   amp_rpp_pkg::phase_type  poll_phase = amp_rpp_pkg::PHASE_IDLE;
   int unsigned             line_len = 0;
   amp_rpp_pkg::prefix_type prefix_st = amp_rpp_pkg::PREFIX_START;
   amp_rpp_pkg::number_type number_st = amp_rpp_pkg::NUM_SKIP;
   logic                    num_negative = 1'b0;
   logic [31:0]             num_magnitude = '0;
   logic                    num_overflow = 1'b0;

   amp_reply_poll_parser #(
      .BUFFER_DEPTH(LINE_DEPTH)
   ) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_op      (req_op),
      .req_rx_byte (req_rx_byte),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_kind    (rsp_kind),
      .rsp_value   (rsp_value),
      .rsp_reply_ok(rsp_reply_ok)
   );

   always #5 clock = ~clock;

   task automatic report_mismatch(string what);
      if (mismatch_count < MAX_PRINTED) begin
         $display("MISMATCH at %0t: %s", $realtime, what);
      end
      mismatch_count++;
   endtask

   task automatic clear_line_state();
      line_len      = 0;
      prefix_st     = amp_rpp_pkg::PREFIX_START;
      number_st     = amp_rpp_pkg::NUM_SKIP;
      num_negative  = 1'b0;
      num_magnitude = '0;
      num_overflow  = 1'b0;
   endtask

   task automatic gather_digit(logic [7:0] c);
      longint unsigned grown;
      if (!num_overflow) begin
         grown = longint'(num_magnitude) * 10 + longint'(c - amp_rpp_pkg::CHAR_ZERO);
         if (grown > longint'(amp_rpp_pkg::MAG_LIMIT)) begin
            num_overflow = 1'b1;
         end else begin
            num_magnitude = grown[31:0];
         end
      end
   endtask

   task automatic scan_number(logic [7:0] c);
      bit is_digit;
      bit is_space;
      is_digit = (c >= amp_rpp_pkg::CHAR_ZERO) && (c <= amp_rpp_pkg::CHAR_NINE);
      is_space = (c == amp_rpp_pkg::CHAR_SPACE) || (c == amp_rpp_pkg::CHAR_TAB) ||
                 (c == amp_rpp_pkg::CHAR_LF) || (c == amp_rpp_pkg::CHAR_VT) ||
                 (c == amp_rpp_pkg::CHAR_FF) || (c == amp_rpp_pkg::CHAR_CR);
      case (number_st)
         amp_rpp_pkg::NUM_SKIP: begin
            if (is_space) begin
            end else if (c == amp_rpp_pkg::CHAR_PLUS) begin
               number_st = amp_rpp_pkg::NUM_SIGN;
            end else if (c == amp_rpp_pkg::CHAR_MINUS) begin
               num_negative = 1'b1;
               number_st    = amp_rpp_pkg::NUM_SIGN;
            end else if (is_digit) begin
               gather_digit(c);
               number_st = amp_rpp_pkg::NUM_DIGITS;
            end else begin
               number_st = amp_rpp_pkg::NUM_STOP;
            end
         end
         amp_rpp_pkg::NUM_SIGN, amp_rpp_pkg::NUM_DIGITS: begin
            if (is_digit) begin
               gather_digit(c);
               number_st = amp_rpp_pkg::NUM_DIGITS;
            end else begin
               number_st = amp_rpp_pkg::NUM_STOP;
            end
         end
         default: begin
         end
      endcase
   endtask

   function automatic logic [31:0] line_number();
      if (prefix_st != amp_rpp_pkg::PREFIX_OK) return '0;
      if (num_overflow) begin
         return num_negative ? amp_rpp_pkg::VALUE_MIN : amp_rpp_pkg::VALUE_MAX;
      end
      if (num_negative) return 32'd0 - num_magnitude;
      if (num_magnitude > amp_rpp_pkg::VALUE_MAX) return amp_rpp_pkg::VALUE_MAX;
      return num_magnitude;
   endfunction

   task automatic predict_beat(logic op, logic [7:0] c);
      poll_result_type res;
      logic [31:0]     number;
      if (op == amp_rpp_pkg::OP_START) begin
         poll_phase = amp_rpp_pkg::PHASE_POS;
         clear_line_state();
         res.kind     = amp_rpp_pkg::KIND_POS_QUERY;
         res.value    = '0;
         res.reply_ok = 1'b0;
         pending_results.push_back(res);
      end else if (c == amp_rpp_pkg::CHAR_CR) begin
         number       = line_number();
         res.reply_ok = (prefix_st == amp_rpp_pkg::PREFIX_OK);
         if (poll_phase == amp_rpp_pkg::PHASE_POS) begin
            res.kind  = amp_rpp_pkg::KIND_POS_DONE;
            res.value = number;
            pending_results.push_back(res);
            poll_phase = amp_rpp_pkg::PHASE_CUR;
         end else if (poll_phase == amp_rpp_pkg::PHASE_CUR) begin
            res.kind  = amp_rpp_pkg::KIND_CUR_DONE;
            res.value = {{16{number[15]}}, number[15:0]};
            pending_results.push_back(res);
            poll_phase = amp_rpp_pkg::PHASE_IDLE;
         end
         clear_line_state();
      end else if (line_len < LINE_DEPTH - 1) begin
         line_len++;
         case (prefix_st)
            amp_rpp_pkg::PREFIX_START: begin
               prefix_st = (c == amp_rpp_pkg::CHAR_V) ?
                           amp_rpp_pkg::PREFIX_V : amp_rpp_pkg::PREFIX_BAD;
            end
            amp_rpp_pkg::PREFIX_V: begin
               prefix_st = (c == amp_rpp_pkg::CHAR_SPACE) ?
                           amp_rpp_pkg::PREFIX_OK : amp_rpp_pkg::PREFIX_BAD;
            end
            amp_rpp_pkg::PREFIX_OK: scan_number(c);
            default: begin
            end
         endcase
      end
   endtask

   function automatic int pick_gap();
      int r;
      if (!gaps_on) return 0;
      r = $urandom_range(0, 99);
      if (r < 70) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic send_beat(logic op, logic [7:0] c);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_op      <= op;
      req_rx_byte <= c;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_beat(op, c);
      beats_sent++;
   endtask

   task automatic send_start();
      send_beat(amp_rpp_pkg::OP_START, 8'($urandom_range(0, 255)));
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) begin
         send_beat(amp_rpp_pkg::OP_BYTE, s[i]);
      end
   endtask

   task automatic send_reply(string s);
      send_text(s);
      send_beat(amp_rpp_pkg::OP_BYTE, amp_rpp_pkg::CHAR_CR);
   endtask

   task automatic send_random_reply(bit truncate);
      logic [7:0] line[$];
      string      corners[7];
      string      digits;
      int         r;
      int         count;
      corners = '{"2147483647", "2147483648", "2147483649", "32767", "32768",
                  "65535", "65536"};
      r = $urandom_range(0, 99);
      if (r < 88) begin
         line.push_back(amp_rpp_pkg::CHAR_V);
         line.push_back(amp_rpp_pkg::CHAR_SPACE);
      end else if (r < 94) begin
         line.push_back(amp_rpp_pkg::CHAR_V);
         line.push_back(8'($urandom_range(0, 255)));
      end else if (r < 97) begin
         line.push_back(8'($urandom_range(0, 255)));
         line.push_back(amp_rpp_pkg::CHAR_SPACE);
      end else begin
         line.push_back(amp_rpp_pkg::CHAR_V);
      end
      count = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
      repeat (count) begin
         case ($urandom_range(0, 4))
            0: line.push_back(amp_rpp_pkg::CHAR_SPACE);
            1: line.push_back(amp_rpp_pkg::CHAR_TAB);
            2: line.push_back(amp_rpp_pkg::CHAR_LF);
            3: line.push_back(amp_rpp_pkg::CHAR_VT);
            default: line.push_back(amp_rpp_pkg::CHAR_FF);
         endcase
      end
      case ($urandom_range(0, 3))
         0: line.push_back(amp_rpp_pkg::CHAR_PLUS);
         1: line.push_back(amp_rpp_pkg::CHAR_MINUS);
         default: begin
         end
      endcase
      r = $urandom_range(0, 99);
      if (r < 12) begin
         digits = corners[$urandom_range(0, 6)];
         for (int i = 0; i < digits.len(); i++) line.push_back(digits[i]);
      end else begin
         if (r < 80) count = $urandom_range(0, 10);
         else if (r < 95) count = $urandom_range(11, 14);
         else count = $urandom_range(25, 35);
         repeat (count) line.push_back(amp_rpp_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
      end
      if ($urandom_range(0, 4) == 0) begin
         line.push_back(8'($urandom_range(0, 255)));
         if ($urandom_range(0, 1) == 0) begin
            line.push_back(amp_rpp_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
         end
      end
      if (truncate) begin
         count = $urandom_range(0, line.size());
         while (line.size() > count) void'(line.pop_back());
      end
      foreach (line[i]) send_beat(amp_rpp_pkg::OP_BYTE, line[i]);
      if (!truncate) send_beat(amp_rpp_pkg::OP_BYTE, amp_rpp_pkg::CHAR_CR);
   endtask

   task automatic test_poll_cycle();
      gaps_on = 1'b0;
      send_start();
      send_reply("v 123");
      send_reply("v -45");
      gaps_on = 1'b1;
      send_start();
      send_reply("v +0007");
      send_reply("v 32768");
      send_start();
      send_reply("v 70000");
      send_reply("v -1");
   endtask

   task automatic test_number_limits();
      send_start();
      send_reply("v 2147483647");
      send_reply("v -2147483648");
      send_start();
      send_reply("v 2147483648");
      send_reply("v -2147483649");
      send_start();
      send_reply("v 99999999999");
      send_reply("v -99999999999");
   endtask

   task automatic test_prefix_and_stops();
      send_start();
      send_reply("x 5");
      send_reply("v5");
      send_start();
      send_reply("");
      send_reply("v");
      send_start();
      send_text("v ");
      send_beat(amp_rpp_pkg::OP_BYTE, amp_rpp_pkg::CHAR_TAB);
      send_beat(amp_rpp_pkg::OP_BYTE, amp_rpp_pkg::CHAR_LF);
      send_beat(amp_rpp_pkg::OP_BYTE, amp_rpp_pkg::CHAR_VT);
      send_beat(amp_rpp_pkg::OP_BYTE, amp_rpp_pkg::CHAR_FF);
      send_reply(" -12");
      send_reply("v -");
      send_start();
      send_text("v 12");
      send_beat(amp_rpp_pkg::OP_BYTE, 8'h00);
      send_reply("34");
      send_reply("v 12a3");
      send_start();
      send_reply("v +");
      send_reply("v  + 5");
   endtask

   task automatic test_line_overflow();
      send_start();
      send_text("v ");
      repeat (29) send_beat(amp_rpp_pkg::OP_BYTE, amp_rpp_pkg::CHAR_ZERO);
      send_reply("77");
      send_text("v ");
      repeat (28) send_beat(amp_rpp_pkg::OP_BYTE, amp_rpp_pkg::CHAR_ZERO);
      send_reply("59999");
   endtask

   task automatic test_idle_and_restart();
      send_beat(amp_rpp_pkg::OP_BYTE, amp_rpp_pkg::CHAR_CR);
      send_text("v 9");
      send_beat(amp_rpp_pkg::OP_BYTE, amp_rpp_pkg::CHAR_CR);
      send_text("v 42");
      send_start();
      send_text("v 1");
      send_beat(amp_rpp_pkg::OP_START, 8'hFF);
      send_reply("v 2");
      send_text("v 3");
      send_beat(amp_rpp_pkg::OP_START, 8'h00);
      send_reply("v 4");
      send_reply("v 5");
      send_reply("v 6");
   endtask

   task automatic test_random_traffic();
      int target;
      int pick;
      int next_toggle;
      target      = beats_sent + RANDOM_BEATS;
      next_toggle = beats_sent;
      while (beats_sent < target) begin
         if (beats_sent >= next_toggle) begin
            gaps_on     = ($urandom_range(0, 3) != 0);
            next_toggle = beats_sent + $urandom_range(50, 200);
         end
         pick = $urandom_range(0, 99);
         if (pick < 75) begin
            send_start();
            send_random_reply(1'b0);
            send_random_reply(1'b0);
         end else if (pick < 90) begin
            send_start();
            send_random_reply(1'b1);
            if ($urandom_range(0, 1) == 0) send_random_reply(1'b0);
         end else begin
            repeat ($urandom_range(1, 10)) begin
               send_beat(amp_rpp_pkg::OP_BYTE, 8'($urandom_range(0, 255)));
            end
            if ($urandom_range(0, 1) == 0) begin
               send_beat(amp_rpp_pkg::OP_BYTE, amp_rpp_pkg::CHAR_CR);
            end
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (stall_hold > 0) begin
         stall_hold <= stall_hold - 1;
      end else if (gaps_on && ($urandom_range(0, 99) < 30)) begin
         rsp_stall  <= 1'b1;
         stall_hold <= ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
                                                    : $urandom_range(0, 3);
      end else begin
         rsp_stall  <= 1'b0;
         stall_hold <= $urandom_range(0, 4);
      end
   end

   always @(posedge clock) begin
      poll_result_type exp;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result kind %0d value %0d",
                                      rsp_kind, rsp_value));
         end else begin
            exp = pending_results.pop_front();
            if (rsp_kind !== exp.kind) begin
               report_mismatch($sformatf("kind %0d, expected %0d", rsp_kind, exp.kind));
            end
            if (rsp_value !== exp.value) begin
               report_mismatch($sformatf("value %0d, expected %0d",
                                         rsp_value, $signed(exp.value)));
            end
            if (rsp_reply_ok !== exp.reply_ok) begin
               report_mismatch($sformatf("reply_ok %0b, expected %0b",
                                         rsp_reply_ok, exp.reply_ok));
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_poll_cycle();
      test_number_limits();
      test_prefix_and_stops();
      test_line_overflow();
      test_idle_and_restart();
      test_random_traffic();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

/* amp_reply_poll_parser.f */
hdl/amp_rpp_pkg.sv
hdl/amp_rpp_line.sv
hdl/amp_reply_poll_parser.sv
tb/testbench.sv
